FILE: rtl/w512rg_pkg.sv
package w512rg_pkg;

	localparam int unsigned POOL_WORDS  = 16;
	localparam int unsigned PTR_W       = 4;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned SPAN_W      = WORD_W + 1;
	localparam int unsigned DIV_STEPS   = WORD_W;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda442d24;
	localparam logic [PTR_W-1:0]  TAP_A       = 4'd13;
	localparam logic [PTR_W-1:0]  TAP_B       = 4'd9;
	localparam logic [PTR_W-1:0]  TAP_LAST    = 4'd15;

	typedef enum logic [1:0] {
		FN_RAW    = 2'd0,
		FN_RANGED = 2'd1,
		FN_SEED   = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_first;
		logic rd_second;
		logic write_n1;
		logic write_n0;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		func_t in_op;
		logic  in_bad;
	} stat_t;

endpackage

FILE: rtl/w512rg_ctrl.sv
module w512rg_ctrl
	import w512rg_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_stall,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD1  = 7'b0000010,
		S_RD2  = 7'b0000100,
		S_CALC = 7'b0001000,
		S_WR   = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t               state_q, state_d;
	logic                 ranged_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					if (stat.in_op == FN_RAW || (stat.in_op == FN_RANGED && !stat.in_bad)) begin
						state_d = S_RD1;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_RD1: begin
				cmd.rd_first = 1'b1;
				state_d      = S_RD2;
			end
			S_RD2: begin
				cmd.rd_second = 1'b1;
				state_d       = S_CALC;
			end
			S_CALC: begin
				cmd.write_n1 = 1'b1;
				state_d      = S_WR;
			end
			S_WR: begin
				cmd.write_n0 = 1'b1;
				cmd.div_init = 1'b1;
				state_d      = ranged_q ? S_DIV : S_DONE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ranged_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				ranged_q <= (stat.in_op == FN_RANGED);
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/w512rg_dpath.sv
module w512rg_dpath
	import w512rg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         func,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic [3:0]         seed_index,
	input  logic [31:0]        seed_value,
	output logic [31:0]        raw_word,
	output logic signed [31:0] ranged_value,
	output logic               range_error
);

	logic [WORD_W-1:0]     mem [POOL_WORDS];
	logic [POOL_WORDS-1:0] vld_q;
	logic [PTR_W-1:0]      ptr_q;

	logic [PTR_W-1:0]      ra, rb, wa;
	logic [WORD_W-1:0]     wd;
	logic                  we;
	logic [WORD_W-1:0]     rda_q, rdb_q;
	logic                  rda_v_q, rdb_v_q;
	logic [WORD_W-1:0]     rda, rdb;

	logic [WORD_W-1:0]     v0_q, va_q;
	logic [WORD_W-1:0]     t1, t2, n1, n0;
	logic [WORD_W-1:0]     n0_q;

	func_t                 op_q;
	logic                  bad_q;
	logic [WORD_W-1:0]     lo_q;
	logic [SPAN_W-1:0]     span_q;
	logic [SPAN_W-1:0]     span_in;

	logic [WORD_W-1:0]     rem_q, wsh_q;
	logic [SPAN_W-1:0]     r_sh, r_sub;

	logic [WORD_W-1:0]     raw_q, ranged_q;
	logic                  err_q;

	assign stat.in_op  = func_t'(func);
	assign stat.in_bad = (high_bound < low_bound);
	assign span_in     = {high_bound[31], high_bound} - {low_bound[31], low_bound}
	                     + SPAN_W'(1);

	// read addresses: first pass fetches v0 and tap a, second tap b and last word
	assign ra = cmd.rd_second ? ptr_q + TAP_B : ptr_q;
	assign rb = cmd.rd_second ? ptr_q + TAP_LAST : ptr_q + TAP_A;

	always_comb begin
		we = 1'b0;
		wa = ptr_q;
		wd = n1;
		if (cmd.accept && func_t'(func) == FN_SEED) begin
			we = 1'b1;
			wa = seed_index;
			wd = seed_value;
		end else if (cmd.write_n1) begin
			we = 1'b1;
		end else if (cmd.write_n0) begin
			we = 1'b1;
			wa = ptr_q + TAP_LAST;
			wd = n0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_first || cmd.rd_second) begin
			rda_q   <= mem[ra];
			rdb_q   <= mem[rb];
			rda_v_q <= vld_q[ra];
			rdb_v_q <= vld_q[rb];
		end
	end

	// unwritten pool words read as zero
	assign rda = rda_v_q ? rda_q : '0;
	assign rdb = rdb_v_q ? rdb_q : '0;

	assign t1 = (v0_q ^ (v0_q << 16)) ^ (va_q ^ (va_q << 15));
	assign t2 = rda ^ (rda >> 11);
	assign n1 = t1 ^ t2;
	assign n0 = (rdb ^ (rdb << 2)) ^ (t1 ^ (t1 << 18)) ^ (t2 << 28)
	            ^ (n1 ^ ((n1 << 5) & TEMPER_MASK));

	// restoring remainder, one word bit per step
	assign r_sh  = {rem_q, wsh_q[WORD_W-1]};
	assign r_sub = r_sh - span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ptr_q <= '0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (cmd.accept && func_t'(func) == FN_SEED) begin
				ptr_q <= '0;
			end else if (cmd.write_n0) begin
				ptr_q <= ptr_q + TAP_LAST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= func_t'(func);
			bad_q  <= stat.in_bad;
			lo_q   <= low_bound;
			span_q <= span_in;
		end
		if (cmd.rd_second) begin
			v0_q <= rda;
			va_q <= rdb;
		end
		if (cmd.write_n1) begin
			n0_q <= n0;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			wsh_q <= n0_q;
		end else if (cmd.div_step) begin
			rem_q <= (r_sh >= span_q) ? r_sub[WORD_W-1:0] : r_sh[WORD_W-1:0];
			wsh_q <= {wsh_q[WORD_W-2:0], 1'b0};
		end
		if (cmd.load_out) begin
			raw_q    <= '0;
			ranged_q <= '0;
			err_q    <= 1'b0;
			case (op_q)
				FN_RAW: begin
					raw_q <= n0_q;
				end
				FN_RANGED: begin
					if (bad_q) begin
						ranged_q <= lo_q;
						err_q    <= 1'b1;
					end else begin
						raw_q    <= n0_q;
						ranged_q <= lo_q + rem_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign raw_word     = raw_q;
	assign ranged_value = ranged_q;
	assign range_error  = err_q;

endmodule

FILE: rtl/well512a_random_generator_unit.sv
// WELL512a generator: a 16-word pool and a rotating pointer, cleared to zero at reset, so
// seed it first. A raw step runs two pool read passes on the two-port pool, one xor step,
// two writes on the single write port and the result load, in that order. A ranged step
// adds the one-bit-per-cycle remainder unit after the writes. A seed load, an unused
// selector and a ranged request with high below low go straight to the result load. The next
// request is taken while a finished result still waits on the response side.
module well512a_random_generator_unit
	import w512rg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         func,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic [3:0]         seed_index,
	input  logic [31:0]        seed_value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [31:0]        raw_word,
	output logic signed [31:0] ranged_value,
	output logic               range_error
);

	cmd_t  cmd;
	stat_t stat;

	w512rg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	w512rg_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (func),
		.low_bound    (low_bound),
		.high_bound   (high_bound),
		.seed_index   (seed_index),
		.seed_value   (seed_value),
		.raw_word     (raw_word),
		.ranged_value (ranged_value),
		.range_error  (range_error)
	);

endmodule
